// File: src/page_table_builder_macros.svh
// Assertion macros shared by the page table builder checkers.
// Depends on nothing; included by the checker file only.
`ifndef PAGE_TABLE_BUILDER_MACROS_SVH
`define PAGE_TABLE_BUILDER_MACROS_SVH

// Clocked property with active-low reset masking.
`define PTB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("page table builder check failed");

// A condition that must never be seen at a clock edge.
`define PTB_NEVER(lbl, clk, rst_n, cond) \
    `PTB_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// File: src/ptb_pkg.sv
// Shared types and constants for the page table builder.
// No dependencies; imported by every module of the block.
package ptb_pkg;

    // Field widths of the stream payloads.
    localparam int VPAGE_W   = 36;
    localparam int PAGE_W    = 40;
    localparam int IDX_W     = 9;
    localparam int SHIFT_W   = 12;
    localparam int ADDR_W    = 52;
    localparam int COUNT_W   = 32;
    localparam int S_DATA_W  = 120;
    localparam int M_DATA_W  = 104;

    // Result kinds carried on the output tuser.
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // Present and write flags of an entry word.
    localparam logic [1:0] ENTRY_FLAGS = 2'b11;

    // Bit positions of the per-item result mask, in output order.
    localparam int STEP_TOP    = 0;
    localparam int STEP_UPPER  = 1;
    localparam int STEP_MIDDLE = 2;
    localparam int STEP_RECORD = 3;
    localparam int STEP_LEAF   = 4;
    localparam int STEPS       = 5;

    // Command queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified item: which results it causes and everything needed to form them.
    typedef struct packed {
        logic [STEPS-1:0]   steps;
        logic [IDX_W-1:0]   top_idx;
        logic [IDX_W-1:0]   upper_idx;
        logic [IDX_W-1:0]   middle_idx;
        logic [IDX_W-1:0]   leaf_idx;
        logic [PAGE_W-1:0]  upper_page;
        logic [PAGE_W-1:0]  middle_page;
        logic [PAGE_W-1:0]  leaf_page;
        logic [PAGE_W-1:0]  phys_page;
        logic [VPAGE_W-1:0] list_idx;
    } t_cmd;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: src/ptb_front.sv
// Front part: accepts requests, decides which tables are new and keeps the run state.
// Depends on ptb_pkg; feeds commands into ptb_queue.
module ptb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ptb_pkg::S_DATA_W-1:0] i_data,
    input  logic                        i_first,
    input  logic                        i_cfg_valid,
    input  logic [ptb_pkg::PAGE_W-1:0]  i_cfg_data,
    input  ptb_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output ptb_pkg::t_cmd               o_cmd,
    output logic [ptb_pkg::PAGE_W-1:0]  o_root
);
    import ptb_pkg::*;

    logic [PAGE_W-1:0]  r_root;
    logic [COUNT_W-1:0] r_taken, n_taken;
    logic [PAGE_W-1:0]  r_upper, r_middle, r_leaf;
    logic [IDX_W-1:0]   r_last_top, r_last_upper, r_last_middle;
    logic [VPAGE_W-1:0] r_list, n_list;
    logic               r_run;

    logic [VPAGE_W-1:0] vpage;
    logic [PAGE_W-1:0]  area;
    logic [COUNT_W-1:0] taken_eff, taken_1, taken_2;
    logic [VPAGE_W-1:0] list_eff;
    logic               run_eff;
    logic [IDX_W-1:0]   top_idx, upper_idx, middle_idx;
    logic               new_up, new_mid, new_leaf;
    logic [PAGE_W-1:0]  page_0, page_1, page_2;
    logic [PAGE_W-1:0]  upper_page, middle_page, leaf_page;
    logic [1:0]         n_new;
    logic               accept;

    // Field split of the request.
    assign vpage      = i_data[VPAGE_W-1:0];
    assign area       = i_data[VPAGE_W+2*PAGE_W-1:VPAGE_W+PAGE_W];
    assign top_idx    = vpage[4*IDX_W-1:3*IDX_W];
    assign upper_idx  = vpage[3*IDX_W-1:2*IDX_W];
    assign middle_idx = vpage[2*IDX_W-1:IDX_W];

    // A new run drops held tables and restarts the counters.
    assign taken_eff = i_first ? '0 : r_taken;
    assign list_eff  = i_first ? vpage : r_list;
    assign run_eff   = i_first ? 1'b0 : r_run;

    // Level classification.
    assign new_up   = !run_eff || (top_idx != r_last_top);
    assign new_mid  = new_up || (upper_idx != r_last_upper);
    assign new_leaf = new_mid || (middle_idx != r_last_middle);

    // Candidate table pages for the first, second and third table taken.
    assign taken_1 = taken_eff + COUNT_W'(1);
    assign taken_2 = taken_eff + COUNT_W'(2);
    assign page_0  = area + PAGE_W'(taken_eff);
    assign page_1  = area + PAGE_W'(taken_1);
    assign page_2  = area + PAGE_W'(taken_2);

    always_comb begin
        upper_page  = r_upper;
        middle_page = r_middle;
        leaf_page   = r_leaf;
        n_new       = 2'd0;
        priority if (new_up) begin
            upper_page  = page_0;
            middle_page = page_1;
            leaf_page   = page_2;
            n_new       = 2'd3;
        end else if (new_mid) begin
            middle_page = page_0;
            leaf_page   = page_1;
            n_new       = 2'd2;
        end else if (new_leaf) begin
            leaf_page   = page_0;
            n_new       = 2'd1;
        end else begin
            n_new       = 2'd0;
        end
    end

    assign n_taken = taken_eff + COUNT_W'(n_new);
    assign n_list  = new_leaf ? (list_eff + VPAGE_W'(1)) : list_eff;

    // Command handed to the back part.
    always_comb begin
        o_cmd.steps                = '0;
        o_cmd.steps[STEP_TOP]      = new_up;
        o_cmd.steps[STEP_UPPER]    = new_mid;
        o_cmd.steps[STEP_MIDDLE]   = new_leaf;
        o_cmd.steps[STEP_RECORD]   = new_leaf;
        o_cmd.steps[STEP_LEAF]     = 1'b1;
        o_cmd.top_idx              = top_idx;
        o_cmd.upper_idx            = upper_idx;
        o_cmd.middle_idx           = middle_idx;
        o_cmd.leaf_idx             = vpage[IDX_W-1:0];
        o_cmd.upper_page           = upper_page;
        o_cmd.middle_page          = middle_page;
        o_cmd.leaf_page            = leaf_page;
        o_cmd.phys_page            = i_data[VPAGE_W+PAGE_W-1:VPAGE_W];
        o_cmd.list_idx             = list_eff;
    end

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;
    assign o_root  = r_root;

    // Run state and root register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root        <= '0;
            r_taken       <= '0;
            r_upper       <= '0;
            r_middle      <= '0;
            r_leaf        <= '0;
            r_last_top    <= '0;
            r_last_upper  <= '0;
            r_last_middle <= '0;
            r_list        <= '0;
            r_run         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_root <= i_cfg_data;
            end
            if (accept) begin
                r_taken       <= n_taken;
                r_upper       <= upper_page;
                r_middle      <= middle_page;
                r_leaf        <= leaf_page;
                r_last_top    <= top_idx;
                r_last_upper  <= upper_idx;
                r_last_middle <= middle_idx;
                r_list        <= n_list;
                r_run         <= 1'b1;
            end
        end
    end

endmodule

// File: src/ptb_queue.sv
// Short command queue that decouples the front part from the back part.
// Depends on ptb_pkg; sits between ptb_front and ptb_back.
module ptb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ptb_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output ptb_pkg::t_cmd      o_head,
    output ptb_pkg::t_q_status o_status
);
    import ptb_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];
    assign do_pop         = i_pop && !o_status.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// File: src/ptb_back.sv
// Back part: walks the results of the head command and drives the output register.
// Depends on ptb_pkg; reads the head of ptb_queue.
module ptb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptb_pkg::t_cmd                 i_head,
    input  ptb_pkg::t_q_status            i_q_status,
    input  logic [ptb_pkg::PAGE_W-1:0]    i_root,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptb_pkg::M_DATA_W-1:0]  o_data,
    output logic                          o_kind,
    output logic                          o_last
);
    import ptb_pkg::*;

    logic [STEPS-1:0]  r_done;
    logic              r_valid;
    logic              r_kind;
    logic              r_last;
    logic [ADDR_W-1:0] r_target, r_value;

    logic [STEPS-1:0]  pend;
    logic [STEPS-1:0]  sel;
    logic              load;
    logic              kind;
    logic              is_last;
    logic [ADDR_W-1:0] target, value;

    assign pend = i_q_status.empty ? '0 : (i_head.steps & ~r_done);
    assign load = (|pend) && (!r_valid || i_ready);

    // Lowest pending result goes out next.
    always_comb begin
        sel     = '0;
        kind    = KIND_ENTRY;
        is_last = 1'b0;
        target  = {i_head.leaf_page, i_head.leaf_idx, 3'b000};
        value   = {i_head.phys_page, 10'd0, ENTRY_FLAGS};
        priority if (pend[STEP_TOP]) begin
            sel[STEP_TOP] = 1'b1;
            target = {i_root, i_head.top_idx, 3'b000};
            value  = {i_head.upper_page, 10'd0, ENTRY_FLAGS};
        end else if (pend[STEP_UPPER]) begin
            sel[STEP_UPPER] = 1'b1;
            target = {i_head.upper_page, i_head.upper_idx, 3'b000};
            value  = {i_head.middle_page, 10'd0, ENTRY_FLAGS};
        end else if (pend[STEP_MIDDLE]) begin
            sel[STEP_MIDDLE] = 1'b1;
            target = {i_head.middle_page, i_head.middle_idx, 3'b000};
            value  = {i_head.leaf_page, 10'd0, ENTRY_FLAGS};
        end else if (pend[STEP_RECORD]) begin
            sel[STEP_RECORD] = 1'b1;
            kind   = KIND_RECORD;
            target = ADDR_W'(i_head.list_idx);
            value  = {i_head.leaf_page, SHIFT_W'(0)};
        end else begin
            sel[STEP_LEAF] = 1'b1;
            is_last = 1'b1;
        end
    end

    assign o_pop = load && is_last;

    // Output register and progress through the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= is_last ? '0 : (r_done | sel);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= kind;
            r_last   <= is_last;
            r_target <= target;
            r_value  <= value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_last  = r_last;
    assign o_data  = {r_value, r_target};

endmodule

// File: src/page_table_builder.sv
// Top level of the four-level page table builder: front, command queue and back.
// Depends on ptb_pkg, ptb_front, ptb_queue and ptb_back.
//
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | tdata: virt_page, phys_page, table_area_page
//          |           |                        | tuser: first_page
//  m_*     | out       | m_tvalid / m_tready    | tdata: target, value; tuser: kind; tlast
//  cfg     | in        | i_cfg_valid/o_cfg_ready| root_table_page
//
// Each request is classified in its accept cycle and yields one to five results; the
// back part sends one result per cycle unless m_tready stalls it, so the results of
// a request go out one after another (five at most, one when no new table is taken).
// A four-entry command queue lets up to four classified requests wait behind the
// output; s_tready falls only when that queue is full. Reset is synchronous, active
// low, and leaves no tables held; the configuration channel is always ready.
module page_table_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // virt_page [35:0], phys_page [75:36], table_area_page [115:76], zero fill above
    input  logic [ptb_pkg::S_DATA_W-1:0]  s_tdata,
    // first_page [0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // target [51:0], value [103:52]
    output logic [ptb_pkg::M_DATA_W-1:0]  m_tdata,
    // kind [0]
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptb_pkg::PAGE_W-1:0]    i_cfg_data
);
    import ptb_pkg::*;

    t_cmd              front_cmd, head_cmd;
    t_q_status         q_status;
    logic              push, pop;
    logic [PAGE_W-1:0] root;
    logic              out_kind;

    assign o_cfg_ready = 1'b1;

    // Request intake and classification.
    ptb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_data      (s_tdata),
        .i_first     (s_tuser[0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_root      (root)
    );

    // Command queue.
    ptb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // Result generation.
    ptb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .i_root     (root),
        .o_pop      (pop),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_data     (m_tdata),
        .o_kind     (out_kind),
        .o_last     (m_tlast)
    );

    assign m_tuser[0] = out_kind;

endmodule

// File: src/ptb_checker.sv
// Port-level checks for the page table builder, attached by bind.
// Depends on ptb_pkg and page_table_builder_macros.svh.
`include "page_table_builder_macros.svh"

module ptb_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptb_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          m_tlast
);
    import ptb_pkg::*;

    logic                out_stall;
    logic [M_DATA_W+1:0] out_word;
    logic                is_entry;
    logic                is_record;
    logic                entry_bad;
    logic                record_bad;

    // Views of the result channel used by the checks below.
    assign out_stall  = m_tvalid && !m_tready;
    assign out_word   = {m_tlast, m_tuser, m_tdata};
    assign is_entry   = m_tvalid && (m_tuser[0] == KIND_ENTRY);
    assign is_record  = m_tvalid && (m_tuser[0] == KIND_RECORD);
    assign entry_bad  = (m_tdata[ADDR_W+1:ADDR_W] != ENTRY_FLAGS) || (m_tdata[2:0] != 3'b000);
    assign record_bad = (m_tdata[ADDR_W+SHIFT_W-1:ADDR_W] != '0);

    // A stalled result keeps its payload.
    `PTB_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> m_tvalid && $stable(out_word))

    // The leaf entry closes every request, so a record never does.
    `PTB_NEVER(a_record_not_last, i_clk, i_rst_n, is_record && m_tlast)

    // Entry writes always carry present and write bits and an aligned address.
    `PTB_NEVER(a_entry_form, i_clk, i_rst_n, is_entry && entry_bad)

    // A record carries a page-aligned table address.
    `PTB_NEVER(a_record_aligned, i_clk, i_rst_n, is_record && record_bad)

endmodule

bind page_table_builder ptb_port_checker u_port_checker (.*);
